// ===== rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// Types, constants and curve tables for the NTC table interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int CURVE_POINTS = 30;
  localparam int ROM_LEN      = 30;
  localparam int IDX_W        = $clog2(CURVE_POINTS);

  localparam int ADC_W   = 24;
  localparam int RES_W   = 20;
  localparam int PROD_W  = ADC_W + RES_W;
  localparam int RATIO_W = 23;
  localparam int SEG_W   = RATIO_W;
  localparam int NUM_W   = RATIO_W + 12;
  localparam int DELTA_W = 14;
  localparam int TEMP_W  = 16;
  localparam int TEMP_EXT_W = 18;

  localparam int FOLD_W      = 24;
  localparam int PRE_SHIFT   = 12;
  localparam int LOW_W       = FOLD_W - PRE_SHIFT;
  localparam int QUO_W       = PROD_W - LOW_W;
  localparam int RECIP_SHIFT = 42;

  localparam int PIPE_LAT = 1 + 3 + 1 + 1 + 1 + DELTA_W + 1;

  typedef logic [RATIO_W-1:0] ratio_t;

  localparam logic [FOLD_W-1:0]  FULL_SCALE = 24'hFFFFFF;
  localparam logic [QUO_W-1:0]   RECIP_LO   = 32'd2741907122;
  localparam logic [RES_W-1:0]   REF_RESET = 20'd10000;
  localparam logic signed [TEMP_W-1:0] TEMP_90_Q88 = 16'sd23040;
  localparam logic signed [TEMP_EXT_W-1:0] TEMP_MAX = 18'sd32767;
  localparam logic signed [TEMP_EXT_W-1:0] TEMP_MIN = -18'sd32768;

  localparam ratio_t CURVE_ROM [2][ROM_LEN] = '{
    '{23'd3448766, 23'd2519990, 23'd1861288, 23'd1388970, 23'd1046741, 23'd796197,
      23'd611097,  23'd473045,  23'd369177,  23'd290377,  23'd230110,  23'd183658,
      23'd147587,  23'd119380,  23'd97170,   23'd79574,   23'd65536,   23'd54276,
      23'd45190,   23'd37816,   23'd31801,   23'd26870,   23'd22805,   23'd19440,
      23'd16641,   23'd14303,   23'd12340,   23'd10687,   23'd9289,    23'd8102},
    '{23'd7906243, 23'd5298147, 23'd3613281, 23'd2505042, 23'd1763646, 23'd1259733,
      23'd912097,  23'd668874,  23'd496448,  23'd372664,  23'd282755,  23'd216505,
      23'd167700,  23'd130954,  23'd103141,  23'd81900,   23'd65536,   23'd52830,
      23'd42887,   23'd35047,   23'd28823,   23'd23849,   23'd19847,   23'd16607,
      23'd13971,   23'd11812,   23'd10036,   23'd8565,    23'd7343,    23'd6322}
  };

  function automatic ratio_t curve_point(input logic curve, input logic [IDX_W-1:0] idx);
    ratio_t pt;
    pt = '0;
    if (int'(idx) < ROM_LEN) begin
      pt = CURVE_ROM[curve][idx];
    end
    return pt;
  endfunction

  function automatic logic signed [TEMP_EXT_W-1:0] base_temp(input logic [IDX_W-1:0] idx);
    int t;
    t = (5 * int'(idx) - 55) * 256;
    return TEMP_EXT_W'(t);
  endfunction

endpackage

// ===== rtl/ntc_table_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// ntc_table_interpolator_unit
// Throughput: one request per cycle; busy stays low, set by the reciprocal
// ratio stages and the fully pipelined segment divider (one quotient bit per
// stage). Results cannot be held off by the receiver.
// Reset: synchronous; clears all valid bits, ref resistance back to 10000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_table_interpolator_unit import ntc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ADC_W-1:0]         in_adc_code,
  input  logic                     in_curve_select,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [RES_W-1:0]         cfg_data,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic                     out_below_table,
  output logic                     out_saturated
);

  logic [RES_W-1:0] ref_r;

  logic              mul_vld_r;
  logic [PROD_W-1:0] mul_prod_r;
  logic              mul_curve_r;

  logic             fq_vld_r;
  logic [QUO_W-1:0] fq_quo_r, fq_quo_nxt;
  logic             fq_curve_r;
  logic [QUO_W-1:0] fq_hi;
  logic [QUO_W:0]   fq_s1;
  logic [FOLD_W:0]  fq_s2;

  logic               rp_vld_r;
  logic [2*QUO_W-1:0] rp_prod_r;
  logic [QUO_W-1:0]   rp_quo_r;
  logic               rp_curve_r;

  logic           rr_vld_r;
  ratio_t         rr_ratio_r;
  logic           rr_curve_r;
  logic [2*QUO_W:0] rr_sum;

  logic                    cmp_vld_r;
  logic [CURVE_POINTS-1:0] cmp_hit_r, cmp_hit_nxt;
  ratio_t                  cmp_ratio_r;
  logic                    cmp_curve_r;

  logic             enc_vld_r;
  logic [IDX_W-1:0] enc_idx_r, enc_idx_nxt;
  logic             enc_below_r, enc_below_nxt;
  ratio_t           enc_ratio_r;
  logic             enc_curve_r;

  logic             seg_vld_r;
  logic [NUM_W-1:0] seg_num_r, seg_num_nxt;
  logic [SEG_W-1:0] seg_d_r, seg_d_nxt;
  logic [IDX_W-1:0] seg_idx_r;
  logic             seg_below_r;
  ratio_t           seg_ti;
  ratio_t           seg_tp;
  ratio_t           seg_diff;

  logic [DELTA_W-1:0] dd_vld_r,   dd_vld_nxt;
  logic [SEG_W-1:0]   dd_rem_r   [DELTA_W];
  logic [SEG_W-1:0]   dd_rem_nxt [DELTA_W];
  logic [DELTA_W-1:0] dd_quo_r   [DELTA_W];
  logic [DELTA_W-1:0] dd_quo_nxt [DELTA_W];
  logic [DELTA_W-1:0] dd_low_r   [DELTA_W];
  logic [DELTA_W-1:0] dd_low_nxt [DELTA_W];
  logic [SEG_W-1:0]   dd_d_r     [DELTA_W];
  logic [SEG_W-1:0]   dd_d_nxt   [DELTA_W];
  logic [IDX_W-1:0]   dd_idx_r   [DELTA_W];
  logic [IDX_W-1:0]   dd_idx_nxt [DELTA_W];
  logic [DELTA_W-1:0] dd_below_r, dd_below_nxt;

  logic signed [TEMP_EXT_W-1:0] fin_temp;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ref_r <= cfg_data;
    end
  end

  // multiply adc code by reference resistance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= start && !busy;
    end
    mul_prod_r  <= PROD_W'(in_adc_code) * PROD_W'(ref_r);
    mul_curve_r <= in_curve_select;
  end

  // divide by full scale: fold the high part back onto the low part
  always_comb begin
    fq_hi      = mul_prod_r[PROD_W-1:LOW_W];
    fq_s1      = (QUO_W+1)'(fq_hi)
               + (QUO_W+1)'({mul_prod_r[LOW_W-1:0], PRE_SHIFT'(0)});
    fq_s2      = (FOLD_W+1)'(fq_s1[QUO_W:FOLD_W]) + (FOLD_W+1)'(fq_s1[FOLD_W-1:0]);
    fq_quo_nxt = fq_hi + QUO_W'(fq_s1[QUO_W:FOLD_W])
               + QUO_W'(fq_s2 >= (FOLD_W+1)'(FULL_SCALE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fq_vld_r <= 1'b0;
    end else begin
      fq_vld_r <= mul_vld_r;
    end
    fq_quo_r   <= fq_quo_nxt;
    fq_curve_r <= mul_curve_r;
  end

  // divide by 625 through the reciprocal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_vld_r <= 1'b0;
    end else begin
      rp_vld_r <= fq_vld_r;
    end
    rp_prod_r  <= (2*QUO_W)'(fq_quo_r) * (2*QUO_W)'(RECIP_LO);
    rp_quo_r   <= fq_quo_r;
    rp_curve_r <= fq_curve_r;
  end

  assign rr_sum = {1'b0, rp_quo_r, QUO_W'(0)} + {1'b0, rp_prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_vld_r <= 1'b0;
    end else begin
      rr_vld_r <= rp_vld_r;
    end
    rr_ratio_r <= rr_sum[2*QUO_W:RECIP_SHIFT];
    rr_curve_r <= rp_curve_r;
  end

  // compare ratio against every curve point except point 0
  always_comb begin
    cmp_hit_nxt = '0;
    for (int i = 1; i < CURVE_POINTS; i++) begin
      cmp_hit_nxt[i] = rr_ratio_r >= curve_point(rr_curve_r, IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= rr_vld_r;
    end
    cmp_hit_r   <= cmp_hit_nxt;
    cmp_ratio_r <= rr_ratio_r;
    cmp_curve_r <= rr_curve_r;
  end

  // pick the first point at or below the ratio
  always_comb begin
    enc_idx_nxt   = '0;
    enc_below_nxt = 1'b1;
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (cmp_hit_r[i]) begin
        enc_idx_nxt   = IDX_W'(i);
        enc_below_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_vld_r <= 1'b0;
    end else begin
      enc_vld_r <= cmp_vld_r;
    end
    enc_idx_r   <= enc_idx_nxt;
    enc_below_r <= enc_below_nxt;
    enc_ratio_r <= cmp_ratio_r;
    enc_curve_r <= cmp_curve_r;
  end

  // segment span and rounded numerator
  always_comb begin
    seg_ti      = curve_point(enc_curve_r, enc_idx_r);
    seg_tp      = curve_point(enc_curve_r, enc_idx_r - IDX_W'(1));
    seg_d_nxt   = (seg_tp > seg_ti) ? SEG_W'(seg_tp - seg_ti) : SEG_W'(1);
    seg_diff    = enc_ratio_r - seg_ti;
    seg_num_nxt = (NUM_W'(seg_diff) << 10) + (NUM_W'(seg_diff) << 8)
                + NUM_W'(seg_d_nxt >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_vld_r <= 1'b0;
    end else begin
      seg_vld_r <= enc_vld_r;
    end
    seg_num_r   <= seg_num_nxt;
    seg_d_r     <= seg_d_nxt;
    seg_idx_r   <= enc_idx_r;
    seg_below_r <= enc_below_r;
  end

  // segment divider: one quotient bit per stage
  always_comb begin
    logic [SEG_W-1:0]   rem_in;
    logic [DELTA_W-1:0] quo_in;
    logic [DELTA_W-1:0] low_in;
    logic [SEG_W-1:0]   d_in;
    logic [IDX_W-1:0]   idx_in;
    logic               below_in;
    logic               vld_in;
    logic [SEG_W:0]     trial;
    logic               ge;
    for (int k = 0; k < DELTA_W; k++) begin
      if (k == 0) begin
        rem_in   = SEG_W'(seg_num_r[NUM_W-1:DELTA_W]);
        quo_in   = '0;
        low_in   = seg_num_r[DELTA_W-1:0];
        d_in     = seg_d_r;
        idx_in   = seg_idx_r;
        below_in = seg_below_r;
        vld_in   = seg_vld_r;
      end else begin
        rem_in   = dd_rem_r[k-1];
        quo_in   = dd_quo_r[k-1];
        low_in   = dd_low_r[k-1];
        d_in     = dd_d_r[k-1];
        idx_in   = dd_idx_r[k-1];
        below_in = dd_below_r[k-1];
        vld_in   = dd_vld_r[k-1];
      end
      trial = {rem_in, low_in[DELTA_W-1]};
      ge    = trial >= {1'b0, d_in};
      dd_rem_nxt[k]   = ge ? SEG_W'(trial - {1'b0, d_in}) : SEG_W'(trial);
      dd_quo_nxt[k]   = {quo_in[DELTA_W-2:0], ge};
      dd_low_nxt[k]   = {low_in[DELTA_W-2:0], 1'b0};
      dd_d_nxt[k]     = d_in;
      dd_idx_nxt[k]   = idx_in;
      dd_below_nxt[k] = below_in;
      dd_vld_nxt[k]   = vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_vld_r <= '0;
    end else begin
      dd_vld_r <= dd_vld_nxt;
    end
    dd_rem_r   <= dd_rem_nxt;
    dd_quo_r   <= dd_quo_nxt;
    dd_low_r   <= dd_low_nxt;
    dd_d_r     <= dd_d_nxt;
    dd_idx_r   <= dd_idx_nxt;
    dd_below_r <= dd_below_nxt;
  end

  // subtract from segment base, clip to Q8.8; below table gives 90 C
  assign fin_temp = base_temp(dd_idx_r[DELTA_W-1])
                  - $signed(TEMP_EXT_W'(dd_quo_r[DELTA_W-1]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dd_vld_r[DELTA_W-1];
    end
    if (dd_below_r[DELTA_W-1]) begin
      out_temperature <= TEMP_90_Q88;
      out_below_table <= 1'b1;
      out_saturated   <= 1'b0;
    end else if (fin_temp > TEMP_MAX) begin
      out_temperature <= TEMP_MAX[TEMP_W-1:0];
      out_below_table <= 1'b0;
      out_saturated   <= 1'b1;
    end else if (fin_temp < TEMP_MIN) begin
      out_temperature <= TEMP_MIN[TEMP_W-1:0];
      out_below_table <= 1'b0;
      out_saturated   <= 1'b1;
    end else begin
      out_temperature <= fin_temp[TEMP_W-1:0];
      out_below_table <= 1'b0;
      out_saturated   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("request did not complete after pipeline latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching request");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_below_table && out_saturated))
    else $error("below_table and saturated both set");

  a_below_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_below_table) |-> (out_temperature == TEMP_90_Q88))
    else $error("below_table result not 90 C");
`endif

endmodule
